// ===== rtl/fm4_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fm4_pkg;
	localparam int unsigned ROWS = 4;
	localparam logic [31:0] QNAN = 32'h7FC00000;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_MUL  = 1'b1
	} req_t;

	// unpacked operand: value = man * 2^(exp - 150)
	typedef struct packed {
		logic        sign;
		logic        nan;
		logic        inf;
		logic        zero;
		logic [9:0]  exp;
		logic [23:0] man;
	} fp_unp_t;

	function automatic fp_unp_t fp_unpack(input logic [31:0] x);
		fp_unp_t u;
		u.sign = x[31];
		u.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
		u.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
		u.zero = (x[30:0] == 31'd0);
		if (x[30:23] == 8'd0) begin
			u.exp = 10'd1;
			u.man = {1'b0, x[22:0]};
		end else begin
			u.exp = {2'b00, x[30:23]};
			u.man = {1'b1, x[22:0]};
		end
		return u;
	endfunction

	// Round a normalized significand to binary32, nearest even.
	// m: bit 49 is the leading one position for a normal result at biased
	// exponent e (signed); lower bits are fraction, bit 0 may be sticky.
	function automatic logic [31:0] fp_round(input logic s, input logic signed [11:0] e,
			input logic [49:0] m);
		logic [49:0] sh;
		logic [25:0] kept;
		logic        st;
		logic [24:0] q;
		logic [11:0] d;
		logic        rb;
		logic [31:0] r;
		logic signed [11:0] be;
		sh = m;
		be = e;
		if (e < 12'sd1) begin
			d = 12'sd1 - e;
			if (d > 12'd49) begin
				sh = {49'd0, |m};
			end else begin
				sh = (m >> d[5:0]) | {49'd0, |(m & ((50'd1 << d[5:0]) - 50'd1))};
			end
			be = 12'sd0;
		end
		kept = sh[49:24];
		st   = |sh[23:0];
		rb   = kept[1] & (st | kept[0] | kept[2]);
		q    = {1'b0, kept[25:2]} + {24'd0, rb};
		if (q[24]) begin
			q  = q >> 1;
			be = be + 12'sd1;
		end
		if (be == 12'sd0 && q[23]) be = 12'sd1;
		if (be >= 12'sd255) r = {s, 8'hFF, 23'd0};
		else r = {s, be[7:0], q[22:0]};
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/fm4_fmul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fm4_fmul import fm4_pkg::*; (
	input  wire         clk,
	input  wire         en,
	input  wire  [31:0] a,
	input  wire  [31:0] b,
	output logic [31:0] y
);
	fp_unp_t ua, ub;
	logic        nan_s1, inf_s1, z_s1, s_s1;
	logic [47:0] p_s1;
	logic signed [11:0] e_s1;
	logic [31:0] y_s2;
	logic [5:0]  lz;
	logic [49:0] mn;
	logic signed [11:0] en2;

	assign ua = fp_unpack(a);
	assign ub = fp_unpack(b);

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1   <= ua.sign ^ ub.sign;
			nan_s1 <= ua.nan | ub.nan | (ua.inf & ub.zero) | (ub.inf & ua.zero);
			inf_s1 <= ua.inf | ub.inf;
			z_s1   <= ua.zero | ub.zero;
			p_s1   <= ua.man * ub.man;
			e_s1   <= $signed({2'b00, ua.exp}) + $signed({2'b00, ub.exp}) - 12'sd126;
		end
	end

	// normalize: leading one of 48-bit product to bit 49
	always_comb begin
		lz = 6'd47;
		for (int i = 0; i < 48; i++) if (p_s1[i]) lz = 6'(47 - i);
		mn  = {p_s1, 2'b00} << lz;
		en2 = e_s1 - $signed({6'd0, lz});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (nan_s1) y_s2 <= QNAN;
			else if (inf_s1) y_s2 <= {s_s1, 8'hFF, 23'd0};
			else if (z_s1) y_s2 <= {s_s1, 31'd0};
			else y_s2 <= fp_round(s_s1, en2, mn);
		end
	end
	assign y = y_s2;
endmodule
`default_nettype wire

// ===== rtl/fm4_fadd.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fm4_fadd import fm4_pkg::*; (
	input  wire         clk,
	input  wire         en,
	input  wire  [31:0] a,
	input  wire  [31:0] b,
	output logic [31:0] y
);
	fp_unp_t ua, ub, ubig, usml;
	logic [9:0]  d;
	logic [49:0] mb, ms;
	logic        spec_s1, s_s1, zs_s1;
	logic [31:0] spec_v_s1;
	logic [50:0] m_s1;
	logic signed [11:0] e_s1;
	logic [5:0]  lz;
	logic [50:0] nrm;
	logic [49:0] mn;
	logic signed [11:0] en2;
	logic [31:0] y_s2;
	logic        swap;

	assign ua = fp_unpack(a);
	assign ub = fp_unpack(b);
	assign swap = (ub.exp > ua.exp) || (ub.exp == ua.exp && ub.man > ua.man);
	assign ubig = swap ? ub : ua;
	assign usml = swap ? ua : ub;
	assign d  = ubig.exp - usml.exp;
	assign mb = {1'b0, ubig.man, 25'd0};
	always_comb begin
		if (d > 10'd48) ms = {49'd0, |usml.man};
		else ms = ({1'b0, usml.man, 25'd0} >> d[5:0])
			| {49'd0, |({1'b0, usml.man, 25'd0} & ((50'd1 << d[5:0]) - 50'd1))};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s1 <= ua.nan | ub.nan | ua.inf | ub.inf;
			if (ua.nan | ub.nan | (ua.inf & ub.inf & (ua.sign != ub.sign))) spec_v_s1 <= QNAN;
			else if (ua.inf) spec_v_s1 <= a;
			else spec_v_s1 <= b;
			s_s1  <= ubig.sign;
			zs_s1 <= ua.sign & ub.sign;
			m_s1  <= (ua.sign == ub.sign) ? {1'b0, mb} + {1'b0, ms} : {1'b0, mb} - {1'b0, ms};
			e_s1  <= $signed({2'b00, ubig.exp});
		end
	end

	// m_s1 bit 48 holds the big operand's hidden position
	always_comb begin
		lz = 6'd50;
		for (int i = 0; i < 51; i++) if (m_s1[i]) lz = 6'(50 - i);
		nrm = m_s1 << lz;
		// leading one to bit 49, fold the dropped bits into sticky
		mn  = {nrm[50:2], |nrm[1:0]};
		en2 = e_s1 + 12'sd2 - $signed({6'd0, lz});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (spec_s1) y_s2 <= spec_v_s1;
			else if (m_s1 == 51'd0) y_s2 <= {zs_s1, 31'd0};
			else y_s2 <= fp_round(s_s1, en2, mn);
		end
	end
	assign y = y_s2;
endmodule
`default_nettype wire

// ===== rtl/fm4_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fm4_lane import fm4_pkg::*; (
	input  wire          clk,
	input  wire          en,
	input  wire  [127:0] arow,
	input  wire  [127:0] bcol,
	output logic [31:0]  y
);
	logic [31:0] t [4];
	logic [31:0] s01, s23;

	for (genvar k = 0; k < 4; k++) begin : g_mul
		fm4_fmul u_mul (.clk, .en, .a(arow[32*k +: 32]), .b(bcol[32*k +: 32]),
			.y(t[k]));
	end
	fm4_fadd u_a01 (.clk, .en, .a(t[0]), .b(t[1]), .y(s01));
	fm4_fadd u_a23 (.clk, .en, .a(t[2]), .b(t[3]), .y(s23));
	fm4_fadd u_fin (.clk, .en, .a(s01), .b(s23), .y(y));
endmodule
`default_nettype wire

// ===== rtl/float_mat4_multiply_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | tdata (low bit up)                         | tuser
// s_axis  | in  | column[1:0], elem0..elem3 (pad to 136)     | req_type
// m_axis  | out | out_column[1:0], prod0..prod3 (pad to 136) | -
// One item per cycle while the output is not stalled; a multiply column passes a
// two-stage multiply and two two-stage add levels. The pipeline advances as a whole
// while the output is free or taken; a stalled output holds every stage.
// Reset clears stage valids only; matrix storage is undefined until loaded.
module float_mat4_multiply_core import fm4_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [135:0] s_axis_tdata,  // column, elem0, elem1, elem2, elem3
	input  wire          s_axis_tuser,  // req_type
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [135:0] m_axis_tdata   // out_column, prod0, prod1, prod2, prod3
);
	localparam int unsigned DEPTH = 6;
	logic [31:0] a_q [4][4];
	logic [DEPTH-1:0] vld_q;
	logic [1:0]  col_q [DEPTH];
	logic        adv;
	logic [127:0] bcol;
	logic [31:0] y [4];
	logic        take;

	assign adv  = !vld_q[DEPTH-1] || m_axis_tready;
	assign s_axis_tready = adv;
	assign take = s_axis_tvalid && adv;
	assign bcol = s_axis_tdata[129:2];

	always_ff @(posedge clk) begin
		if (take && req_t'(s_axis_tuser) == REQ_LOAD) begin
			for (int r = 0; r < 4; r++) a_q[s_axis_tdata[1:0]][r] <= s_axis_tdata[2+32*r +: 32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], take && req_t'(s_axis_tuser) == REQ_MUL};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_q[0] <= s_axis_tdata[1:0];
			for (int k = 1; k < DEPTH; k++) col_q[k] <= col_q[k-1];
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_lane
		fm4_lane u_lane (.clk, .en(adv),
			.arow({a_q[3][i], a_q[2][i], a_q[1][i], a_q[0][i]}), .bcol, .y(y[i]));
	end

	assign m_axis_tvalid = vld_q[DEPTH-1];
	assign m_axis_tdata  = {6'd0, y[3], y[2], y[1], y[0], col_q[DEPTH-1]};
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import fm4_pkg::*;

	localparam logic [31:0] CANON_NAN = 32'h7FC00000;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		req_t        kind;
		logic [1:0]  col;
		logic [31:0] e3;
		logic [31:0] e2;
		logic [31:0] e1;
		logic [31:0] e0;
	} col_req_t;

	typedef struct packed {
		logic [1:0]  col;
		logic [31:0] p3;
		logic [31:0] p2;
		logic [31:0] p1;
		logic [31:0] p0;
	} prod_col_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata;
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [135:0] m_axis_tdata;

	float_mat4_multiply_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	col_req_t    pending_reqs[$];
	prod_col_t   expected_cols[$];
	logic [31:0] mat_a[4][4];
	int          errors = 0;
	int          send_idle_pct = 20;
	int          recv_idle_pct = 47;
	bit          stim_done = 0;
	bit          in_xfer = 0;
	longint      cycles = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// ---------------- binary32 arithmetic ----------------
	function automatic bit f_is_nan(logic [31:0] x);
		return x[30:23] == 8'hFF && x[22:0] != 0;
	endfunction

	function automatic bit f_is_inf(logic [31:0] x);
		return x[30:0] == 31'h7F800000;
	endfunction

	function automatic void f_split(logic [31:0] x, output logic [63:0] m, output int e);
		if (x[30:23] == 0) begin
			m = {41'd0, x[22:0]};
			e = -149;
		end else begin
			m = {40'd0, 1'b1, x[22:0]};
			e = int'(x[30:23]) - 150;
		end
	endfunction

	// round s * m * 2^e to nearest even; bit 0 of m may be sticky
	function automatic logic [31:0] f_round(logic s, int e, logic [63:0] m);
		int p, lsb, sh, be;
		logic [63:0] q, half, rem;
		if (m == 0) return {s, 31'd0};
		p = 63;
		while (!m[p]) p--;
		lsb = p + e - 23;
		if (lsb < -149) lsb = -149;
		sh = lsb - e;
		if (sh <= 0) begin
			q = m << (-sh);
		end else begin
			if (sh > p + 1) return {s, 31'd0};
			half = 64'd1 << (sh - 1);
			rem = m & ((half << 1) - 1);
			q = m >> sh;
			if (rem > half || (rem == half && q[0])) q++;
		end
		if (q >= (64'd1 << 24)) begin
			q >>= 1;
			lsb++;
		end
		if (q >= (64'd1 << 23)) begin
			be = lsb + 150;
			if (be >= 255) return {s, 8'hFF, 23'd0};
			return {s, be[7:0], q[22:0]};
		end
		return {s, q[30:0]};
	endfunction

	function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
		logic s;
		logic [63:0] ma, mb;
		int ea, eb;
		s = a[31] ^ b[31];
		if (f_is_nan(a) || f_is_nan(b)) return CANON_NAN;
		if (f_is_inf(a) || f_is_inf(b)) begin
			if (a[30:0] == 0 || b[30:0] == 0) return CANON_NAN;
			return {s, 8'hFF, 23'd0};
		end
		f_split(a, ma, ea);
		f_split(b, mb, eb);
		return f_round(s, ea + eb, ma * mb);
	endfunction

	function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
		logic sa, sb, s, ts;
		logic [63:0] ma, mb, big, lit, m, tm;
		int ea, eb, d, te;
		sa = a[31];
		sb = b[31];
		if (f_is_nan(a) || f_is_nan(b)) return CANON_NAN;
		if (f_is_inf(a) && f_is_inf(b)) return (sa == sb) ? a : CANON_NAN;
		if (f_is_inf(a)) return a;
		if (f_is_inf(b)) return b;
		f_split(a, ma, ea);
		f_split(b, mb, eb);
		if (ea < eb) begin
			tm = ma; te = ea; ts = sa;
			ma = mb; ea = eb; sa = sb;
			mb = tm; eb = te; sb = ts;
		end
		d = ea - eb;
		big = ma << 38;
		lit = (d <= 38) ? (mb << (38 - d)) : {63'd0, mb != 0};
		if (sa == sb) begin
			m = big + lit; s = sa;
		end else if (big >= lit) begin
			m = big - lit; s = sa;
		end else begin
			m = lit - big; s = sb;
		end
		if (m == 0) return {sa & sb, 31'd0};
		return f_round(s, ea - 38, m);
	endfunction

	// apply one request to the model matrix; queue a product column for multiplies
	task automatic predict_column(col_req_t r);
		logic [31:0] b[4];
		logic [31:0] p[4];
		b = '{r.e0, r.e1, r.e2, r.e3};
		if (r.kind == REQ_LOAD) begin
			for (int i = 0; i < 4; i++) mat_a[r.col][i] = b[i];
		end else begin
			for (int i = 0; i < 4; i++)
				p[i] = f_add(f_add(f_mul(mat_a[0][i], b[0]), f_mul(mat_a[1][i], b[1])),
					f_add(f_mul(mat_a[2][i], b[2]), f_mul(mat_a[3][i], b[3])));
			expected_cols.push_back('{r.col, p[3], p[2], p[1], p[0]});
		end
	endtask

	// ---------------- stimulus values ----------------
	function automatic logic [31:0] rand_float();
		logic [31:0] x;
		x = $urandom;
		case ($urandom_range(0, 11))
			0: x[30:23] = 8'h00;
			1: x[30:23] = 8'hFF;
			2: x[30:0] = 31'd0;
			3: x[30:23] = 8'($urandom_range(1, 20));
			4: x[30:23] = 8'($urandom_range(235, 254));
			5: x[30:0] = (x[0] ? 31'h7F800000 : 31'h7FC00000);
			6: x[30:23] = 8'd127;
			default: x[30:23] = 8'($urandom_range(110, 144));
		endcase
		return x;
	endfunction

	function automatic col_req_t make_req(req_t k, logic [1:0] c, logic [31:0] a,
			logic [31:0] b, logic [31:0] d, logic [31:0] e);
		return '{k, c, e, d, b, a};
	endfunction

	task automatic queue_full_load();
		for (int c = 0; c < 4; c++)
			pending_reqs.push_back(make_req(REQ_LOAD, c[1:0], rand_float(), rand_float(),
				rand_float(), rand_float()));
	endtask

	// ---------------- driver ----------------
	always @(negedge clk) begin
		if (arst_n) begin
			// hold the offered item until its transfer
			if (pending_reqs.size() != 0 && ($urandom_range(0, 99) >= send_idle_pct
					|| (s_axis_tvalid && !in_xfer))) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {pending_reqs[0].e3, pending_reqs[0].e2,
					pending_reqs[0].e1, pending_reqs[0].e0, pending_reqs[0].col};
				s_axis_tuser  <= pending_reqs[0].kind;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		col_req_t  acc;
		prod_col_t got, exp_c;
		if (arst_n) begin
			cycles++;
			in_xfer = s_axis_tvalid && s_axis_tready;
			if (in_xfer) begin
				acc = '{req_t'(s_axis_tuser), s_axis_tdata[1:0], s_axis_tdata[129:98],
					s_axis_tdata[97:66], s_axis_tdata[65:34], s_axis_tdata[33:2]};
				predict_column(acc);
				void'(pending_reqs.pop_front());
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata[1:0], m_axis_tdata[129:98], m_axis_tdata[97:66],
					m_axis_tdata[65:34], m_axis_tdata[33:2]};
				if (expected_cols.size() == 0) begin
					$display("%0t: unexpected product column %h", $time, got);
					errors++;
				end else begin
					exp_c = expected_cols.pop_front();
					if (got.col !== exp_c.col)
						$display("%0t: column exp %0d got %0d", $time, exp_c.col, got.col);
					if (got.p0 !== exp_c.p0)
						$display("%0t: prod0 exp %h got %h", $time, exp_c.p0, got.p0);
					if (got.p1 !== exp_c.p1)
						$display("%0t: prod1 exp %h got %h", $time, exp_c.p1, got.p1);
					if (got.p2 !== exp_c.p2)
						$display("%0t: prod2 exp %h got %h", $time, exp_c.p2, got.p2);
					if (got.p3 !== exp_c.p3)
						$display("%0t: prod3 exp %h got %h", $time, exp_c.p3, got.p3);
					if (got !== exp_c) errors++;
				end
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// ---------------- sequence ----------------
	initial begin
		logic [31:0] ext[$];
		int n;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = 0;
		m_axis_tready = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: identity, then edge values
		for (int c = 0; c < 4; c++)
			pending_reqs.push_back(make_req(REQ_LOAD, c[1:0], (c == 0) ? 32'h3F800000 : 0,
				(c == 1) ? 32'h3F800000 : 0, (c == 2) ? 32'h3F800000 : 0,
				(c == 3) ? 32'h3F800000 : 0));
		ext = '{32'h00000000, 32'h80000000, 32'h00000001, 32'h807FFFFF, 32'h7F7FFFFF,
			32'hFF800000, 32'h7F800001, 32'hFFFFFFFF, 32'h3F800000, 32'h00800000};
		for (int k = 0; k < 10; k += 2)
			pending_reqs.push_back(make_req(REQ_MUL, k[1:0] ^ 2'd3, ext[k], ext[k+1],
				ext[(k+2)%10], ext[(k+3)%10]));
		// x + (-x) and overflow
		pending_reqs.push_back(make_req(REQ_LOAD, 2'd1, 32'hBF800000, 32'hBF800000,
			32'hBF800000, 32'hBF800000));
		pending_reqs.push_back(make_req(REQ_MUL, 2'd0, 32'h40000000, 32'h40000000, 0, 0));
		pending_reqs.push_back(make_req(REQ_LOAD, 2'd0, 32'h7F7FFFFF, 32'h7F7FFFFF,
			32'h7F800000, 32'h00000000));
		pending_reqs.push_back(make_req(REQ_MUL, 2'd2, 32'h7F7FFFFF, 32'h80000000,
			32'h7F800000, 32'hFF800000));
		pending_reqs.push_back(make_req(REQ_MUL, 2'd1, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000));
		pending_reqs.push_back(make_req(REQ_MUL, 2'd3, 32'h00000001, 32'h00000001,
			32'h3F000000, 32'h3F000000));

		// random: mostly multiplies, occasional column reloads
		for (int ph = 0; ph < 3; ph++) begin
			n = 0;
			while (n < 570) begin
				if ($urandom_range(0, 9) == 0) begin
					if ($urandom_range(0, 3) == 0) queue_full_load();
					else pending_reqs.push_back(make_req(REQ_LOAD, 2'($urandom_range(0, 3)),
						rand_float(), rand_float(), rand_float(), rand_float()));
				end else begin
					pending_reqs.push_back(make_req(REQ_MUL, 2'($urandom_range(0, 3)),
						rand_float(), rand_float(), rand_float(), rand_float()));
				end
				n++;
			end
			while (pending_reqs.size() != 0) @(posedge clk);
			if (ph == 0) begin
				send_idle_pct = 47;
				recv_idle_pct = 20;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		end

		while (expected_cols.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/fm4_pkg.sv
rtl/fm4_fmul.sv
rtl/fm4_fadd.sv
rtl/fm4_lane.sv
rtl/float_mat4_multiply_core.sv
verif/tb_top.sv
